[rtl/mf5_pkg.sv]
// shared types and constants for the five-tap median filter
package mf5_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WIN_TAPS    = 5;
    localparam int HIST_DEPTH  = WIN_TAPS - 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // slot index into the window, also used for counts up to five
    typedef logic [2:0] slot_t;

    typedef sample_t window_t [WIN_TAPS];

    localparam slot_t SLOT_MID  = 3'd2;
    localparam slot_t SLOT_NEW  = 3'd4;
    localparam slot_t MAX_SEEN  = 3'd4;
    localparam slot_t TAP_COUNT = 3'd5;

endpackage

[rtl/mf5_median.sv]
// median of window slots lo..4, mean of the two middle values for even counts
module mf5_median (
    input  mf5_pkg::window_t win,
    input  mf5_pkg::slot_t   lo,
    output mf5_pkg::sample_t median
);
    import mf5_pkg::*;

    logic [WIN_TAPS-1:0] tap_ok;
    slot_t               rank [WIN_TAPS];
    slot_t               taps;
    slot_t               hi_rank;
    slot_t               lo_rank;
    sample_t             hi_val;
    sample_t             lo_val;
    logic [SAMPLE_BITS:0] pair_sum;

    assign taps    = TAP_COUNT - lo;
    assign hi_rank = taps >> 1;
    // odd count: both picks are the same element
    assign lo_rank = taps[0] ? hi_rank : hi_rank - 3'd1;

    always_comb begin
        for (int j = 0; j < WIN_TAPS; j++) begin
            tap_ok[j] = (slot_t'(j) >= lo);
        end
    end

    // rank of each tap among the valid ones, ties broken by slot order
    always_comb begin
        for (int j = 0; j < WIN_TAPS; j++) begin
            rank[j] = '0;
            for (int k = 0; k < WIN_TAPS; k++) begin
                if (k != j && tap_ok[k]) begin
                    if ((win[k] < win[j]) || (win[k] == win[j] && k < j)) begin
                        rank[j] = rank[j] + 3'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        hi_val = '0;
        lo_val = '0;
        for (int j = 0; j < WIN_TAPS; j++) begin
            if (tap_ok[j] && rank[j] == hi_rank) begin
                hi_val = win[j];
            end
            if (tap_ok[j] && rank[j] == lo_rank) begin
                lo_val = win[j];
            end
        end
    end

    // exact sum, arithmetic halving floors toward minus infinity
    assign pair_sum = {hi_val[SAMPLE_BITS-1], hi_val} + {lo_val[SAMPLE_BITS-1], lo_val};
    assign median   = sample_t'(pair_sum[SAMPLE_BITS:1]);

endmodule

[rtl/median_filter_five_tap.sv]
// five-tap streaming median filter with record-end window clipping
// the job register loads at the accepting edge and the result register loads from it
//   when the result register is empty or m_ready is high
// throughput: one sample per cycle while m_ready is high; an end-of-record sample yields
//   up to three result words, holding s_ready low until the job register emits the last
// reset: synchronous active-low aresetn clears history, sample count and valids
module median_filter_five_tap (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mf5_pkg::sample_t s_sample,
    input  logic             s_end_of_record,
    output logic             m_valid,
    input  logic             m_ready,
    output mf5_pkg::sample_t m_median,
    output logic             m_final_res
);
    import mf5_pkg::*;

    sample_t hist_reg [HIST_DEPTH];
    sample_t hist_next [HIST_DEPTH];
    slot_t   seen_reg, seen_next;

    logic    job_valid_reg, job_valid_next;
    window_t job_win_reg, job_win_next;
    slot_t   job_first_reg, job_first_next;
    slot_t   job_slot_reg, job_slot_next;
    logic    job_last_reg, job_last_next;

    logic    m_valid_reg, m_valid_next;
    sample_t m_median_reg, m_median_next;
    logic    m_final_reg, m_final_next;

    logic    s_accept;
    logic    out_free;
    logic    emit;
    logic    job_done;
    logic    final_word;
    slot_t   in_first;
    slot_t   slot_lo;
    slot_t   cur_lo;
    window_t in_win;
    sample_t med;

    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = job_valid_reg && out_free;
    assign final_word = job_last_reg && (job_slot_reg == SLOT_NEW);
    assign job_done   = emit && (!job_last_reg || job_slot_reg == SLOT_NEW);
    assign s_ready    = !job_valid_reg || job_done;
    assign s_accept   = s_valid && s_ready;

    assign in_first = MAX_SEEN - seen_reg;
    assign slot_lo  = job_slot_reg - SLOT_MID;
    assign cur_lo   = (slot_lo > job_first_reg) ? slot_lo : job_first_reg;

    always_comb begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            in_win[i] = hist_reg[HIST_DEPTH-1-i];
        end
        in_win[WIN_TAPS-1] = s_sample;
    end

    mf5_median u_median (
        .win    (job_win_reg),
        .lo     (cur_lo),
        .median (med)
    );

    always_comb begin
        hist_next      = hist_reg;
        seen_next      = seen_reg;
        job_valid_next = job_valid_reg;
        job_win_next   = job_win_reg;
        job_first_next = job_first_reg;
        job_slot_next  = job_slot_reg;
        job_last_next  = job_last_reg;
        m_valid_next   = m_valid_reg;
        m_median_next  = m_median_reg;
        m_final_next   = m_final_reg;

        if (emit) begin
            m_valid_next  = 1'b1;
            m_median_next = med;
            m_final_next  = final_word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (job_done) begin
            job_valid_next = 1'b0;
        end else if (emit) begin
            job_slot_next = job_slot_reg + 3'd1;
        end

        if (s_accept) begin
            job_win_next   = in_win;
            job_first_next = in_first;
            job_last_next  = s_end_of_record;
            if (s_end_of_record) begin
                // flush the pending positions of this record
                job_valid_next = 1'b1;
                job_slot_next  = (in_first > SLOT_MID) ? in_first : SLOT_MID;
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    hist_next[i] = '0;
                end
                seen_next = '0;
            end else begin
                job_valid_next = (seen_reg >= SLOT_MID);
                job_slot_next  = SLOT_MID;
                for (int i = HIST_DEPTH-1; i > 0; i--) begin
                    hist_next[i] = hist_reg[i-1];
                end
                hist_next[0] = s_sample;
                if (seen_reg < MAX_SEEN) begin
                    seen_next = seen_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            seen_reg      <= '0;
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            seen_reg      <= seen_next;
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        job_win_reg   <= job_win_next;
        job_first_reg <= job_first_next;
        job_slot_reg  <= job_slot_next;
        job_last_reg  <= job_last_next;
        m_median_reg  <= m_median_next;
        m_final_reg   <= m_final_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_median    = m_median_reg;
    assign m_final_res = m_final_reg;

endmodule

[tb/sv/median_filter_five_tap_test.sv]
// testbench for the five-tap median filter: directed and random records checked against a scoreboard
`timescale 1ns / 1ps

module median_filter_five_tap_test;
    import mf5_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 100;
    localparam int REPORT_LIMIT = 10;

    // directed records of length 1, 2, 2, 3, 4, 7 and 6
    localparam int DIR_COUNT = 25;
    localparam int DIR_VALS [DIR_COUNT] = '{
        8388607,
        -8388608, 8388607,
        -1, 0,
        8388607, 8388607, -8388608,
        3, -5, 7, -2,
        -8388608, -8388608, 8388607, 8388607, 0, -1, 1,
        -3, 6, -8, 1, -7, 2
    };
    // end-of-record flags at positions 0, 2, 4, 7, 11, 18 and 24
    localparam bit [DIR_COUNT-1:0] DIR_LAST = 25'h1040895;

    class median_scoreboard;
        typedef struct packed {
            sample_t median;
            logic    last;
        } med_word_t;

        med_word_t expected_q [$];
        sample_t   hist [HIST_DEPTH];
        int        seen;
        int        bad_words;

        function new();
            clear_record();
            bad_words = 0;
        endfunction

        function void clear_record();
            foreach (hist[i]) hist[i] = '0;
            seen = 0;
        endfunction

        // median of w[lo..4]; even counts take the floor of the mean of the middle pair
        function sample_t window_mid(window_t w, int lo);
            sample_t                     s [WIN_TAPS];
            sample_t                     v;
            logic signed [SAMPLE_BITS:0] total;
            int                          m, i, j;
            m = WIN_TAPS - lo;
            for (i = 0; i < m; i++) s[i] = w[lo + i];
            for (i = 1; i < m; i++) begin
                v = s[i];
                j = i - 1;
                while (j >= 0 && s[j] > v) begin
                    s[j + 1] = s[j];
                    j--;
                end
                s[j + 1] = v;
            end
            if (m % 2 == 1) return s[m / 2];
            total = s[m / 2 - 1] + s[m / 2];
            return total[SAMPLE_BITS:1];
        endfunction

        function void note_sample(sample_t x, logic last);
            window_t w;
            int      first, lo, i;
            first = HIST_DEPTH - seen;
            w[0] = hist[3];
            w[1] = hist[2];
            w[2] = hist[1];
            w[3] = hist[0];
            w[4] = x;
            if (!last) begin
                if (seen >= 2) expected_q.push_back('{window_mid(w, first), 1'b0});
                hist[3] = hist[2];
                hist[2] = hist[1];
                hist[1] = hist[0];
                hist[0] = x;
                if (seen < HIST_DEPTH) seen++;
            end else begin
                // flush the positions two back, one back and current that are in this record
                for (i = 2; i <= 4; i++) begin
                    if (i >= first) begin
                        lo = (i - 2 < first) ? first : i - 2;
                        expected_q.push_back('{window_mid(w, lo), (i == 4)});
                    end
                end
                clear_record();
            end
        endfunction

        function void check_median(sample_t got, logic got_last);
            med_word_t want;
            if (expected_q.size() == 0) begin
                bad_words++;
                if (bad_words <= REPORT_LIMIT)
                    $display("unexpected result word: median=%0d final_res=%0b",
                             got, got_last);
            end else begin
                want = expected_q.pop_front();
                if (want.median !== got || want.last !== got_last) begin
                    bad_words++;
                    if (bad_words <= REPORT_LIMIT)
                        $display({"mismatch: expected median=%0d final_res=%0b, ",
                                  "got median=%0d final_res=%0b"},
                                 want.median, want.last, got, got_last);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic    aclk;
    logic    aresetn         = 1'b0;
    logic    s_valid         = 1'b0;
    logic    s_ready;
    sample_t s_sample        = '0;
    logic    s_end_of_record = 1'b0;
    logic    m_valid;
    logic    m_ready         = 1'b0;
    sample_t m_median;
    logic    m_final_res;

    median_scoreboard sb;
    int send_idle_pct = 15;
    int recv_idle_pct = 76;
    logic hold_req = 1'b0;
    int cycle_count = 0;

    median_filter_five_tap u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median        (m_median),
        .m_final_res     (m_final_res)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("median_filter_five_tap verification failed");
            $finish;
        end
    end

    // result word monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_median(m_median, m_final_res);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : rx_drive
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic sample_t pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: v = 8388607;
            1: v = -8388608;
            2, 3: v = int'($urandom_range(0, 8)) - 4;
            default: v = int'($urandom());
        endcase
        return sample_t'(v);
    endfunction

    function automatic int pick_record_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 6);
        if (r < 9) return $urandom_range(7, 16);
        return $urandom_range(17, 40);
    endfunction

    // offer one word, wait for the handshake, then tell the scoreboard
    task automatic push_word(input sample_t x, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample        <= x;
        s_end_of_record <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(x, last);
    endtask

    task automatic send_records(input int item_goal);
        int sent, len, i;
        sent = 0;
        while (sent < item_goal) begin
            len = pick_record_len();
            for (i = 0; i < len; i++) push_word(pick_sample(), i == len - 1);
            sent += len;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        int k;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIR_COUNT; k++) push_word(sample_t'(DIR_VALS[k]), DIR_LAST[k]);
        send_records(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 76;
        recv_idle_pct = 15;
        send_records(PHASE_ITEMS);
        wait_drained();

        // no idling; long receiver hold-off while the sender keeps offering words
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 1'b1;
        send_records(PHASE_ITEMS);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (sb.bad_words == 0 && sb.pending() == 0) begin
            $display("median_filter_five_tap verification clean");
        end else begin
            $display("median_filter_five_tap verification failed");
        end
        $finish;
    end

endmodule
